>>> src/gcd3_pkg.sv
// Shared types for the three-operand GCD block: sequencer and engine state codes.
package gcd3_pkg;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START1,
    SEQ_PAIR1,
    SEQ_PAIR2
  } seq_state_t;

  // Pairwise GCD engine states
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_REDUCE,
    ENG_SCALE,
    ENG_DONE
  } eng_state_t;

endpackage

>>> src/gcd3_pair.sv
// Pairwise binary GCD engine: one shift or subtract step per cycle.
module gcd3_pair import gcd3_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] op_x,
  input  logic [WIDTH-1:0] op_y,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int KW = $clog2(WIDTH + 1);

  eng_state_t       state_r, state_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [WIDTH-1:0] diff;
  logic             x_ge_y;

  // Shared compare and subtract unit
  assign x_ge_y = (x_r >= y_r);
  assign diff   = x_ge_y ? (x_r - y_r) : (y_r - x_r);

  // Hold state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    k_r <= k_nxt;
  end

  // Next state: strip common twos, reduce odd pair, then restore the twos
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    case (state_r)
      ENG_IDLE, ENG_DONE: begin
        if (start) begin
          x_nxt     = op_x;
          y_nxt     = op_y;
          k_nxt     = '0;
          state_nxt = ENG_REDUCE;
        end
      end
      ENG_REDUCE: begin
        if (x_r == '0) begin
          x_nxt     = y_r;
          state_nxt = ENG_SCALE;
        end else if (y_r == '0) begin
          state_nxt = ENG_SCALE;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_ge_y) begin
          x_nxt = diff >> 1;
        end else begin
          y_nxt = diff >> 1;
        end
      end
      ENG_SCALE: begin
        if (k_r == '0) begin
          state_nxt = ENG_DONE;
        end else begin
          x_nxt = x_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  assign done   = (state_r == ENG_DONE);
  assign result = x_r;

endmodule

>>> src/gcd_of_three_signed.sv
// Top level of the three-operand signed GCD block: stream ports and sequencer.
//
// Usage: a word on the in_ channel carries three signed operands; one word on
// the out_ channel returns the GCD of their magnitudes (zero operands drop out,
// all zeros give zero). The block works on one word at a time.
// The GCD is formed as gcd(gcd(|a|,|b|),|c|) by a single binary GCD engine that
// performs one shift or one subtract per cycle, reused for both pairs.
// Every shift or subtract drops at least one operand bit, and each restored
// factor of two was paid for by a shift of both operands; the time a word takes
// from accept to out_tvalid is set by the operand bit patterns.
// Flow control: in_tready is high only while the sequencer is idle, so the next
// word is taken once the previous result has been loaded into the output
// register, even if that result is still waiting to be taken.
// Stall: if out_tready stays low, a second finished result waits in the engine
// until the output register frees. A result of 2^(DATA_WIDTH-1) saturates.
// Reset (synchronous, rst_n low) returns to idle and drops any pending word.
module gcd_of_three_signed import gcd3_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // first_value, second_value, third_value, from bit 0 up; zero padded
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // divisor from bit 0 up; zero padded
  output logic [((DATA_WIDTH-1+7)/8)*8-1:0]      out_tdata
);

  localparam int W      = DATA_WIDTH;
  localparam int OUT_W  = ((DATA_WIDTH - 1 + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - (DATA_WIDTH - 1);

  seq_state_t       state_r, state_nxt;
  logic [W-1:0]     a_r, b_r, c_r;
  logic [W-1:0]     a_mag, b_mag, c_mag;
  logic [W-1:0]     op_x, op_y, eng_res;
  logic             eng_start, eng_done;
  logic             out_valid_r, out_valid_nxt;
  logic [W-2:0]     div_r, div_nxt;
  logic             in_acc, out_free, load_out;

  // Form magnitudes; the most negative value yields 2^(W-1) exactly
  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign a_mag = mag(in_tdata[W-1:0]);
  assign b_mag = mag(in_tdata[2*W-1:W]);
  assign c_mag = mag(in_tdata[3*W-1:2*W]);

  assign in_tready = (state_r == SEQ_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Capture operand magnitudes on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r <= a_mag;
      b_r <= b_mag;
      c_r <= c_mag;
    end
  end

  // Hold sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  // Sequence the two pairwise passes and load the output register
  always_comb begin
    state_nxt = state_r;
    eng_start = 1'b0;
    op_x      = a_r;
    op_y      = b_r;
    load_out  = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        if (in_acc) begin
          state_nxt = SEQ_START1;
        end
      end
      SEQ_START1: begin
        eng_start = 1'b1;
        state_nxt = SEQ_PAIR1;
      end
      SEQ_PAIR1: begin
        op_x = eng_res;
        op_y = c_r;
        if (eng_done) begin
          eng_start = 1'b1;
          state_nxt = SEQ_PAIR2;
        end
      end
      SEQ_PAIR2: begin
        if (eng_done && out_free) begin
          load_out  = 1'b1;
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  // Track output valid and load the divisor, saturating a result that does not fit the divisor field
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    div_nxt       = div_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      div_nxt       = eng_res[W-1] ? {(W-1){1'b1}} : eng_res[W-2:0];
    end
  end

  gcd3_pair #(
    .WIDTH (W)
  ) u_pair (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (eng_start),
    .op_x   (op_x),
    .op_y   (op_y),
    .done   (eng_done),
    .result (eng_res)
  );

  assign out_tvalid = out_valid_r;

  generate
    if (OUT_PAD > 0) begin : g_pad
      assign out_tdata = {{OUT_PAD{1'b0}}, div_r};
    end else begin : g_nopad
      assign out_tdata = div_r;
    end
  endgenerate

endmodule

>>> src/gcd3_checker.sv
// Port-level checker for the three-operand GCD block, bound to the top level.
module gcd3_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [((DATA_WIDTH-1+7)/8)*8-1:0]      out_tdata
);

  // Drop ready for the next word once a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready stayed high after an accepted word");

  // No result appears straight after an accept with an empty output
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |=> !out_tvalid)
    else $error("result appeared one cycle after accept");

  // A result that follows a taken one at once comes with the sequencer idle
  a_gap_after_output: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> (!out_tvalid || in_tready))
    else $error("result followed without the sequencer returning to idle");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind gcd_of_three_signed gcd3_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_gcd3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/testbench.sv
// Self-checking testbench for the three-operand signed GCD block on stream ports.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPERAND_BITS = 32;
  localparam int RANDOM_WORDS = 1800;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_CYCLES = 300;
  localparam int POS_LIMIT    = 2147483647;

  typedef struct {
    int          first_value;
    int          second_value;
    int          third_value;
    int unsigned gap;
    bit          drain_first;
  } operand_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  operand_word_t operand_queue[$];
  bit [30:0]     expected_divisors[$];
  operand_word_t staged_word;
  operand_word_t on_bus;
  bit            staged = 1'b0;
  bit            on_bus_valid = 1'b0;
  int unsigned   hold_off = 0;
  int unsigned   words_sent = 0;
  int unsigned   results_seen = 0;
  int unsigned   stall_left = 0;
  bit            rx_steady = 1'b0;
  int unsigned   quiet_cycles = 0;
  int unsigned   fault_count = 0;

  gcd_of_three_signed #(.DATA_WIDTH(OPERAND_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Magnitude of a two's complement operand; the most negative value gives 2^31
  function automatic bit [31:0] operand_magnitude(int value);
    bit [31:0] raw;
    raw = value;
    return raw[31] ? -raw : raw;
  endfunction

  // Euclid's remainder loop on two magnitudes
  function automatic bit [31:0] euclid_pair(bit [31:0] x, bit [31:0] y);
    bit [31:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // GCD of the three magnitudes, saturated to the divisor field
  function automatic bit [30:0] gcd_of_operands(int a, int b, int c);
    bit [31:0] g;
    g = euclid_pair(euclid_pair(operand_magnitude(a), operand_magnitude(b)),
                    operand_magnitude(c));
    if (g > 32'h7fff_ffff) g = 32'h7fff_ffff;
    return g[30:0];
  endfunction

  // Any operand in range: the most negative value is excluded
  function automatic int any_operand();
    bit [31:0] raw;
    raw = $urandom;
    if (raw == 32'h8000_0000) raw = 32'h8000_0001;
    return int'(raw);
  endfunction

  // Common factor of varied size, often carrying factors of two
  function automatic int unsigned pick_factor();
    longint unsigned base;
    longint unsigned wide;
    base = 1 + ($urandom >> $urandom_range(1, 31));
    if (base > POS_LIMIT) base = POS_LIMIT;
    wide = base << $urandom_range(0, 12);
    return (wide <= POS_LIMIT) ? int'(wide) : int'(base);
  endfunction

  // Random multiple of a factor with random sign, kept inside the range
  function automatic int scaled_operand(int unsigned factor);
    longint prod;
    prod = longint'(factor) * longint'($urandom_range(0, POS_LIMIT / factor));
    return $urandom_range(0, 1) ? -int'(prod) : int'(prod);
  endfunction

  task automatic queue_word(int a, int b, int c, int unsigned gap, bit drain);
    operand_word_t w;
    w.first_value  = a;
    w.second_value = b;
    w.third_value  = c;
    w.gap          = gap;
    w.drain_first  = drain;
    operand_queue.push_back(w);
  endtask

  // Sender: present queued words, hold off for each word's gap, drain on request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_divisors.push_back(gcd_of_operands(on_bus.first_value,
                                                    on_bus.second_value,
                                                    on_bus.third_value));
        words_sent++;
        on_bus_valid = 1'b0;
      end
      if (!on_bus_valid && !staged && operand_queue.size() != 0) begin
        staged_word = operand_queue.pop_front();
        staged      = 1'b1;
        hold_off    = staged_word.gap;
      end
      if (!on_bus_valid && staged) begin
        if (hold_off != 0) begin
          hold_off--;
        end else if (!staged_word.drain_first || words_sent == results_seen) begin
          on_bus       = staged_word;
          on_bus_valid = 1'b1;
          staged       = 1'b0;
        end
      end
      in_tvalid <= on_bus_valid;
      in_tdata  <= {on_bus.third_value, on_bus.second_value, on_bus.first_value};
    end
  end

  // Receiver: stall at random after each word outside steady phases, check against the oldest expectation
  always @(posedge clk) begin
    bit [31:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_divisors.size() == 0) begin
          $display("%0t: unexpected divisor word, expected none, got %0d",
                   $time, out_tdata);
          fault_count++;
        end else begin
          want = {1'b0, expected_divisors.pop_front()};
          if (out_tdata !== want) begin
            $display("%0t: divisor wrong, expected %0d, got %0d", $time, want, out_tdata);
            fault_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) rx_steady = ~rx_steady;
        stall_left = rx_steady ? 0 : $urandom_range(0, 10);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_tready <= (stall_left == 0);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned factor;
    int          a;
    int          b;
    int          c;
    bit          burst;
    int unsigned gap;
    burst = 1'b0;

    // Zero operands, lone operands, range extremes
    queue_word(0, 0, 0, 0, 1'b0);
    queue_word(-7, 0, 0, 0, 1'b0);
    queue_word(0, 12, 0, 0, 1'b0);
    queue_word(0, 0, -POS_LIMIT, 0, 1'b0);
    queue_word(POS_LIMIT, 0, 0, 3, 1'b0);
    queue_word(POS_LIMIT, -POS_LIMIT, POS_LIMIT, 0, 1'b0);
    queue_word(-POS_LIMIT, -POS_LIMIT, 0, 0, 1'b0);
    queue_word(1, 1, 1, 0, 1'b0);
    queue_word(-1, 0, 0, 5, 1'b0);
    queue_word(1, POS_LIMIT, -1, 0, 1'b0);
    // Powers of two and shared factors of two
    queue_word(1 << 30, -(1 << 30), 1 << 29, 0, 1'b0);
    queue_word(1 << 30, 0, -(1 << 30), 0, 1'b0);
    queue_word(3 << 20, 5 << 20, -(7 << 20), 0, 1'b0);
    queue_word(1 << 30, 3, 0, 10, 1'b0);
    // Long Euclid chains (consecutive Fibonacci numbers) and shared odd factors
    queue_word(1836311903, 1134903170, 0, 0, 1'b0);
    queue_word(-1836311903, 1134903170, 701408733, 0, 1'b0);
    queue_word(1000000007, -2000000014, 0, 0, 1'b0);
    queue_word(2147483646, -1073741823, 715827882, 0, 1'b0);
    queue_word(-12, -18, -30, 0, 1'b0);
    queue_word(17, 19, 23, 0, 1'b0);
    queue_word(-1431655765, 0, 1431655765, 0, 1'b0);
    queue_word(32'h5555_5555, 32'h2aaa_aaaa, 32'h7fff_fffe, 0, 1'b0);

    // Random words: mostly shared factors so the divisor is rarely just one
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 10);
      factor = pick_factor();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = any_operand();
          b = any_operand();
          c = any_operand();
        end
        9: begin
          a = $urandom_range(0, 1) ? 0 : scaled_operand(factor);
          b = $urandom_range(0, 1) ? 0 : any_operand();
          c = $urandom_range(0, 1) ? 0 : scaled_operand(factor);
        end
        default: begin
          a = scaled_operand(factor);
          b = scaled_operand(factor);
          c = scaled_operand(factor);
        end
      endcase
      queue_word(a, b, c, gap, (i % 500 == 0));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (operand_queue.size() == 0 && !staged && !on_bus_valid &&
          results_seen == words_sent);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_divisors.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
